// File: hw/rtl/gprs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Grid rectangle sum package
// Shared widths, codes and the sequencer state type of the rectangle sum block.
// ----------------------------------------------------------------------------
package gprs_pkg;

  // Default grid limits.
  localparam int DEF_MAX_ROWS = 64;
  localparam int DEF_MAX_COLS = 64;

  // Payload widths.
  localparam int DATA_W     = 64;
  localparam int COORD_W    = 6;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 7;

  // Register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_ROWS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COLS = 2'd1;

  // Operation codes.
  localparam logic OP_ASSIGN = 1'b0;
  localparam logic OP_QUERY  = 1'b1;

  // Status codes.
  localparam logic STATUS_DONE    = 1'b0;
  localparam logic STATUS_OUTSIDE = 1'b1;

  // Sequencer states.
  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_CELL_RD,
    ST_CELL_WR,
    ST_UPD_RD,
    ST_UPD_WR,
    ST_TERM,
    ST_QRY_RD,
    ST_QRY_ACC,
    ST_DONE
  } state_t;

endpackage

// File: hw/rtl/grid_point_set_rect_sum_tree.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Grid rectangle sum
// Two-dimensional binary indexed sum tree over a configurable grid of signed
// 64-bit cells, with single-cell assignment and inclusive rectangle queries.
// ----------------------------------------------------------------------------
// Operation: an assignment reads and rewrites the cell, then walks the tree,
// each node visit being one read and one write of the single tree RAM port; a
// query runs up to 4 prefix walks, each node visit being one read of that port.
// One request is in flight at a time; a finished result may wait in the output
// register while the next request is taken. Reset and every write of the row or
// column register run a clearing pass over all DEPTH addresses of both RAMs,
// during which no requests are taken.
module grid_point_set_rect_sum_tree
  import gprs_pkg::*;
#(
  parameter int MAX_ROWS = DEF_MAX_ROWS,
  parameter int MAX_COLS = DEF_MAX_COLS
) (
  input  logic                            clk,
  input  logic                            rst,
  // Request channel.
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic                            operation,
  input  logic [gprs_pkg::COORD_W-1:0]    cell_row,
  input  logic [gprs_pkg::COORD_W-1:0]    cell_col,
  input  logic signed [gprs_pkg::DATA_W-1:0] new_value,
  input  logic [gprs_pkg::COORD_W-1:0]    top_row,
  input  logic [gprs_pkg::COORD_W-1:0]    left_col,
  input  logic [gprs_pkg::COORD_W-1:0]    bottom_row,
  input  logic [gprs_pkg::COORD_W-1:0]    right_col,
  // Result channel.
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic signed [gprs_pkg::DATA_W-1:0] rect_sum,
  output logic                            status,
  // Register write channel.
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [gprs_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [gprs_pkg::CFG_DATA_W-1:0] cfg_data
);

  // Address widths of one grid axis and tree index widths (1-based, up to MAX).
  localparam int RAW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int CAW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int AW  = RAW + CAW;
  localparam int DEPTH = 1 << AW;
  localparam int RIW = $clog2(MAX_ROWS + 1);
  localparam int CIW = $clog2(MAX_COLS + 1);
  localparam int RCW = (RIW > COORD_W + 1) ? RIW : COORD_W + 1;
  localparam int CCW = (CIW > COORD_W + 1) ? CIW : COORD_W + 1;

  state_t state, state_next;

  logic [CFG_DATA_W-1:0] rows_cfg, cols_cfg;
  logic [AW-1:0]         clr_cnt;

  // Request registers.
  logic [RAW-1:0]        row_q;
  logic [CAW-1:0]        col_q;
  logic [DATA_W-1:0]     val_q;
  logic [DATA_W-1:0]     delta;
  logic [DATA_W-1:0]     acc;
  logic                  res_status;
  logic [RIW-1:0]        qr_hi, qr_lo;
  logic [CIW-1:0]        qc_hi, qc_lo;
  logic [1:0]            term;
  logic [RIW-1:0]        fi;
  logic [CIW-1:0]        fj;

  // RAM ports.
  logic                  cell_we, tree_we;
  logic [AW-1:0]         cell_addr, tree_addr;
  logic [DATA_W-1:0]     cell_wdata, tree_wdata;
  logic [DATA_W-1:0]     cell_rdata, tree_rdata;

  logic cfg_hit, in_acc, out_load;

  // Effective grid size, clamped to 1..MAX.
  logic [RCW-1:0] rows_ext;
  logic [CCW-1:0] cols_ext;
  logic [RIW-1:0] eff_rows;
  logic [CIW-1:0] eff_cols;

  always_comb begin
    rows_ext = RCW'(rows_cfg);
    cols_ext = CCW'(cols_cfg);
    if (rows_cfg == '0) begin
      eff_rows = RIW'(1);
    end else if (rows_ext > RCW'(MAX_ROWS)) begin
      eff_rows = RIW'(MAX_ROWS);
    end else begin
      eff_rows = rows_ext[RIW-1:0];
    end
    if (cols_cfg == '0) begin
      eff_cols = CIW'(1);
    end else if (cols_ext > CCW'(MAX_COLS)) begin
      eff_cols = CIW'(MAX_COLS);
    end else begin
      eff_cols = cols_ext[CIW-1:0];
    end
  end

  // Request decode: range check and clipped prefix counts.
  logic [RCW-1:0] bot1, rb1;
  logic [CCW-1:0] rgt1, cr1;
  logic           asg_ok, q_nonempty;

  always_comb begin
    bot1 = RCW'(bottom_row) + RCW'(1);
    rgt1 = CCW'(right_col) + CCW'(1);
    rb1  = (bot1 < RCW'(eff_rows)) ? bot1 : RCW'(eff_rows);
    cr1  = (rgt1 < CCW'(eff_cols)) ? rgt1 : CCW'(eff_cols);
    asg_ok = (RCW'(cell_row) < RCW'(eff_rows)) && (CCW'(cell_col) < CCW'(eff_cols));
    q_nonempty = (RCW'(top_row) < rb1) && (CCW'(left_col) < cr1);
  end

  // Tree index steps.
  logic [RIW:0]   upd_i_nxt;
  logic [CIW:0]   upd_j_nxt;
  logic [RIW-1:0] qry_i_nxt, fi_low, term_ti;
  logic [CIW-1:0] qry_j_nxt, fj_low, term_tj;
  logic           term_neg, term_last, term_skip;
  logic           upd_j_end, upd_i_end;

  always_comb begin
    fi_low    = fi & (~fi + RIW'(1));
    fj_low    = fj & (~fj + CIW'(1));
    upd_i_nxt = {1'b0, fi} + {1'b0, fi_low};
    upd_j_nxt = {1'b0, fj} + {1'b0, fj_low};
    upd_i_end = upd_i_nxt > (RIW+1)'(MAX_ROWS);
    upd_j_end = upd_j_nxt > (CIW+1)'(MAX_COLS);
    qry_i_nxt = fi - fi_low;
    qry_j_nxt = fj - fj_low;
    term_ti   = term[0] ? qr_lo : qr_hi;
    term_tj   = term[1] ? qc_lo : qc_hi;
    term_neg  = term[0] ^ term[1];
    term_last = (term == 2'd3);
    term_skip = (term_ti == '0) || (term_tj == '0);
  end

  assign cfg_ready = 1'b1;
  assign cfg_hit   = cfg_valid && cfg_ready && (cfg_index == CFG_ROWS || cfg_index == CFG_COLS);
  assign in_acc    = in_valid && !in_stall;
  assign out_load  = (state == ST_DONE) && (!out_valid || !out_stall);

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: begin
        if (clr_cnt == AW'(DEPTH - 1)) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid) begin
          if (operation == OP_ASSIGN) begin
            state_next = asg_ok ? ST_CELL_RD : ST_DONE;
          end else begin
            state_next = q_nonempty ? ST_TERM : ST_DONE;
          end
        end
      end
      ST_CELL_RD: state_next = ST_CELL_WR;
      ST_CELL_WR: state_next = ST_UPD_RD;
      ST_UPD_RD:  state_next = ST_UPD_WR;
      ST_UPD_WR: begin
        if (upd_j_end && upd_i_end) state_next = ST_DONE;
        else state_next = ST_UPD_RD;
      end
      ST_TERM: begin
        if (!term_skip) state_next = ST_QRY_RD;
        else if (term_last) state_next = ST_DONE;
      end
      ST_QRY_RD: state_next = ST_QRY_ACC;
      ST_QRY_ACC: begin
        if (qry_j_nxt != '0 || qry_i_nxt != '0) state_next = ST_QRY_RD;
        else if (term_last) state_next = ST_DONE;
        else state_next = ST_TERM;
      end
      ST_DONE: begin
        if (out_load) state_next = ST_IDLE;
      end
      default: state_next = ST_CLEAR;
    endcase
    if (cfg_hit) state_next = ST_CLEAR;
  end

  // RAM controls.
  always_comb begin
    in_stall   = (state != ST_IDLE);
    cell_we    = 1'b0;
    tree_we    = 1'b0;
    cell_addr  = {row_q, col_q};
    tree_addr  = {RAW'(fi - RIW'(1)), CAW'(fj - CIW'(1))};
    cell_wdata = val_q;
    tree_wdata = tree_rdata + delta;
    unique case (state)
      ST_CLEAR: begin
        cell_we    = 1'b1;
        tree_we    = 1'b1;
        cell_addr  = clr_cnt;
        tree_addr  = clr_cnt;
        cell_wdata = '0;
        tree_wdata = '0;
      end
      ST_CELL_WR: cell_we = 1'b1;
      ST_UPD_WR:  tree_we = 1'b1;
      default: begin
      end
    endcase
  end

  // Sequencer state and configuration.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      clr_cnt  <= '0;
      rows_cfg <= CFG_DATA_W'(64);
      cols_cfg <= CFG_DATA_W'(64);
    end else begin
      state <= state_next;
      if (cfg_hit) begin
        clr_cnt <= '0;
        if (cfg_index == CFG_ROWS) rows_cfg <= cfg_data;
        else cols_cfg <= cfg_data;
      end else if (state == ST_CLEAR) begin
        clr_cnt <= clr_cnt + AW'(1);
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        if (in_acc) begin
          row_q      <= RAW'(RCW'(cell_row));
          col_q      <= CAW'(CCW'(cell_col));
          val_q      <= new_value;
          acc        <= '0;
          term       <= 2'd0;
          qr_hi      <= rb1[RIW-1:0];
          qr_lo      <= RIW'(RCW'(top_row));
          qc_hi      <= cr1[CIW-1:0];
          qc_lo      <= CIW'(CCW'(left_col));
          res_status <= (operation == OP_ASSIGN && !asg_ok) ? STATUS_OUTSIDE : STATUS_DONE;
        end
      end
      ST_CELL_WR: begin
        delta <= val_q - cell_rdata;
        fi    <= RIW'(RCW'(row_q) + RCW'(1));
        fj    <= CIW'(CCW'(col_q) + CCW'(1));
      end
      ST_UPD_WR: begin
        if (upd_j_end) begin
          fi <= upd_i_nxt[RIW-1:0];
          fj <= CIW'(CCW'(col_q) + CCW'(1));
        end else begin
          fj <= upd_j_nxt[CIW-1:0];
        end
      end
      ST_TERM: begin
        if (term_skip) begin
          term <= term + 2'd1;
        end else begin
          fi <= term_ti;
          fj <= term_tj;
        end
      end
      ST_QRY_ACC: begin
        acc <= term_neg ? (acc - tree_rdata) : (acc + tree_rdata);
        if (qry_j_nxt != '0) begin
          fj <= qry_j_nxt;
        end else if (qry_i_nxt != '0) begin
          fi <= qry_i_nxt;
          fj <= term_tj;
        end else begin
          term <= term + 2'd1;
        end
      end
      default: begin
      end
    endcase
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      rect_sum <= acc;
      status   <= res_status;
    end
  end

  // Cell values, used to turn an assignment into a tree delta.
  gprs_ram #(.WIDTH(DATA_W), .DEPTH(DEPTH)) u_cell_ram (
    .clk   (clk),
    .we    (cell_we),
    .addr  (cell_addr),
    .wdata (cell_wdata),
    .rdata (cell_rdata)
  );

  // Binary indexed tree nodes.
  gprs_ram #(.WIDTH(DATA_W), .DEPTH(DEPTH)) u_tree_ram (
    .clk   (clk),
    .we    (tree_we),
    .addr  (tree_addr),
    .wdata (tree_wdata),
    .rdata (tree_rdata)
  );

  // No request is taken while the store is being cleared.
  a_clear_stalls: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CLEAR) |-> in_stall)
    else $error("request taken during clearing pass");

  // A register write restarts the clearing pass.
  a_cfg_clears: assert property (@(posedge clk) disable iff (rst)
    cfg_hit |=> (state == ST_CLEAR))
    else $error("register write did not clear the store");

  // Query walks only read valid 1-based tree nodes.
  a_qry_index: assert property (@(posedge clk) disable iff (rst)
    (state == ST_QRY_RD) |-> (fi != '0 && fj != '0))
    else $error("query read of tree index zero");

  // Update walks stay inside the tree.
  a_upd_index: assert property (@(posedge clk) disable iff (rst)
    (state == ST_UPD_RD) |-> (fi != '0 && fj != '0 &&
      int'(fi) <= MAX_ROWS && int'(fj) <= MAX_COLS))
    else $error("update index outside tree");

endmodule

// File: hw/rtl/gprs_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Single port RAM
// One read or write per cycle; read data is registered.
// ----------------------------------------------------------------------------
module gprs_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write into the array, registered read of the old contents (read-first).
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule
